// ===== rtl/sexpr_pkg.sv =====
package sexpr_pkg;

    // lexer limits
    localparam logic [7:0] SYMBOL_MAX        = 8'd254;
    localparam logic [7:0] MAX_COMMENT_DEPTH = 8'd255;
    localparam logic [19:0] LINE_MAX         = 20'hFFFFF;

    // token kinds
    localparam logic [1:0] KIND_SPECIAL = 2'd0;
    localparam logic [1:0] KIND_STRING  = 2'd1;
    localparam logic [1:0] KIND_SYMBOL  = 2'd2;

    // result queue size
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one token result, without the line count
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] token_kind;
        logic       char_valid;
        logic       token_last;
    } result_t;

    // what the lexer hands to the queue for one accepted byte
    typedef struct packed {
        logic        v0;
        logic        v1;
        result_t     r0;
        result_t     r1;
        logic [19:0] line;
    } lex_out_t;

    // one queue entry
    typedef struct packed {
        result_t     res;
        logic [19:0] line;
    } entry_t;

endpackage

// ===== rtl/sexpr_lexer.sv =====
module sexpr_lexer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         char_byte,
    output sexpr_pkg::lex_out_t lex
);

    typedef enum logic [2:0] {
        M_START = 3'd0,
        M_LINE  = 3'd1,
        M_BLOCK = 3'd2,
        M_STR   = 3'd3,
        M_ESC   = 3'd4,
        M_SYM   = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        P_NONE = 2'd0,
        P_HASH = 2'd1,
        P_BAR  = 2'd2
    } pend_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLSH = 8'h5C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_R     = 8'h72;

    function automatic logic is_special(input logic [7:0] ch);
        logic r;
        case (ch)
            8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D,
            8'h27, 8'h60, 8'h23, 8'h5C, 8'h2C, 8'h40: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    mode_t       mode_reg, mode_next;
    pend_t       pend_reg, pend_next;
    logic [7:0]  depth_reg, depth_next;
    logic [7:0]  slen_reg, slen_next;
    logic [19:0] line_reg, line_next;

    // effect of a byte handled at token start
    mode_t             st_mode;
    logic              st_hash;
    logic              st_emit;
    logic              st_bump;
    logic [7:0]        st_slen;
    sexpr_pkg::result_t st_res;
    logic              first_last;

    // main decode
    logic              bump;
    logic              v0, v1;
    sexpr_pkg::result_t r0, r1;
    logic [7:0]        slen_inc;
    logic              sym_split;
    logic              sym_char;

    assign first_last = (8'd1 >= sexpr_pkg::SYMBOL_MAX);
    assign slen_inc   = slen_reg + 8'd1;
    assign sym_split  = (slen_inc >= sexpr_pkg::SYMBOL_MAX);
    assign sym_char   = (char_byte > CH_SPACE) && !is_special(char_byte);

    // token start handling
    always_comb
    begin
        st_mode = M_START;
        st_hash = 1'b0;
        st_emit = 1'b0;
        st_bump = 1'b0;
        st_slen = 8'd0;
        st_res  = '0;
        if (char_byte == CH_NUL)
        begin
            st_mode = M_START;
        end
        else if (char_byte <= CH_SPACE)
        begin
            st_bump = (char_byte == CH_NL);
        end
        else if (char_byte == CH_SEMI)
        begin
            st_mode = M_LINE;
        end
        else if (char_byte == CH_HASH)
        begin
            st_hash = 1'b1;
        end
        else if (is_special(char_byte))
        begin
            st_emit = 1'b1;
            st_res  = '{char_byte, sexpr_pkg::KIND_SPECIAL, 1'b1, 1'b1};
        end
        else if (char_byte == CH_QUOTE)
        begin
            st_mode = M_STR;
        end
        else
        begin
            st_emit = 1'b1;
            st_res  = '{char_byte, sexpr_pkg::KIND_SYMBOL, 1'b1, first_last};
            st_mode = first_last ? M_START : M_SYM;
            st_slen = first_last ? 8'd0 : 8'd1;
        end
    end

    // per-mode next state and results
    always_comb
    begin
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        depth_next = depth_reg;
        slen_next  = slen_reg;
        bump       = 1'b0;
        v0         = 1'b0;
        v1         = 1'b0;
        r0         = '0;
        r1         = '0;
        case (mode_reg)
            M_LINE:
            begin
                if (char_byte == CH_NUL)
                begin
                    mode_next = M_START;
                end
                else if (char_byte == CH_NL)
                begin
                    bump      = 1'b1;
                    mode_next = M_START;
                end
            end
            M_BLOCK:
            begin
                if (char_byte == CH_NUL)
                begin
                    mode_next  = M_START;
                    depth_next = 8'd0;
                    pend_next  = P_NONE;
                end
                else if (pend_reg == P_BAR && char_byte == CH_HASH)
                begin
                    pend_next = P_NONE;
                    if (depth_reg > 8'd0)
                    begin
                        depth_next = depth_reg - 8'd1;
                    end
                    if (depth_reg <= 8'd1)
                    begin
                        mode_next = M_START;
                    end
                end
                else if (pend_reg == P_HASH && char_byte == CH_BAR)
                begin
                    pend_next = P_NONE;
                    if (depth_reg < sexpr_pkg::MAX_COMMENT_DEPTH)
                    begin
                        depth_next = depth_reg + 8'd1;
                    end
                end
                else if (char_byte == CH_BAR)
                begin
                    pend_next = P_BAR;
                end
                else if (char_byte == CH_HASH)
                begin
                    pend_next = P_HASH;
                end
                else
                begin
                    pend_next = P_NONE;
                end
            end
            M_STR:
            begin
                if (char_byte == CH_NUL || char_byte == CH_QUOTE)
                begin
                    v0        = 1'b1;
                    r0        = '{CH_NUL, sexpr_pkg::KIND_STRING, 1'b0, 1'b1};
                    mode_next = M_START;
                end
                else if (char_byte == CH_BSLSH)
                begin
                    mode_next = M_ESC;
                end
                else
                begin
                    v0 = 1'b1;
                    r0 = '{char_byte, sexpr_pkg::KIND_STRING, 1'b1, 1'b0};
                end
            end
            M_ESC:
            begin
                if (char_byte == CH_NUL)
                begin
                    v0        = 1'b1;
                    r0        = '{CH_NUL, sexpr_pkg::KIND_STRING, 1'b0, 1'b1};
                    mode_next = M_START;
                end
                else
                begin
                    mode_next = M_STR;
                    // escapes other than these four are dropped
                    if (char_byte == CH_N)
                    begin
                        v0 = 1'b1;
                        r0 = '{CH_NL, sexpr_pkg::KIND_STRING, 1'b1, 1'b0};
                    end
                    else if (char_byte == CH_T)
                    begin
                        v0 = 1'b1;
                        r0 = '{CH_TAB, sexpr_pkg::KIND_STRING, 1'b1, 1'b0};
                    end
                    else if (char_byte == CH_R)
                    begin
                        v0 = 1'b1;
                        r0 = '{CH_CR, sexpr_pkg::KIND_STRING, 1'b1, 1'b0};
                    end
                    else if (char_byte == CH_BSLSH)
                    begin
                        v0 = 1'b1;
                        r0 = '{CH_BSLSH, sexpr_pkg::KIND_STRING, 1'b1, 1'b0};
                    end
                end
            end
            M_SYM:
            begin
                if (sym_char)
                begin
                    v0        = 1'b1;
                    r0        = '{char_byte, sexpr_pkg::KIND_SYMBOL, 1'b1, sym_split};
                    slen_next = sym_split ? 8'd0 : slen_inc;
                    mode_next = sym_split ? M_START : M_SYM;
                end
                else
                begin
                    // end marker, then the byte is taken at token start
                    v0        = 1'b1;
                    r0        = '{CH_NUL, sexpr_pkg::KIND_SYMBOL, 1'b0, 1'b1};
                    v1        = st_emit;
                    r1        = st_res;
                    mode_next = st_mode;
                    slen_next = st_slen;
                    bump      = st_bump;
                    if (st_hash)
                    begin
                        pend_next = P_HASH;
                    end
                end
            end
            default:
            begin
                pend_next = P_NONE;
                if (pend_reg == P_HASH && char_byte == CH_BAR)
                begin
                    mode_next  = M_BLOCK;
                    depth_next = 8'd1;
                end
                else if (pend_reg == P_HASH)
                begin
                    // held hash goes out, then the byte at token start
                    v0        = 1'b1;
                    r0        = '{CH_HASH, sexpr_pkg::KIND_SPECIAL, 1'b1, 1'b1};
                    v1        = st_emit;
                    r1        = st_res;
                    mode_next = st_mode;
                    slen_next = st_slen;
                    bump      = st_bump;
                    pend_next = st_hash ? P_HASH : P_NONE;
                end
                else
                begin
                    v0        = st_emit;
                    r0        = st_res;
                    mode_next = st_mode;
                    slen_next = st_slen;
                    bump      = st_bump;
                    pend_next = st_hash ? P_HASH : P_NONE;
                end
            end
        endcase
    end

    // saturating line counter
    assign line_next = (bump && line_reg != sexpr_pkg::LINE_MAX) ? line_reg + 20'd1 : line_reg;

    assign lex.v0   = v0;
    assign lex.v1   = v1;
    assign lex.r0   = r0;
    assign lex.r1   = r1;
    assign lex.line = line_next;

    // lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_START;
            pend_reg  <= P_NONE;
            depth_reg <= 8'd0;
            slen_reg  <= 8'd0;
            line_reg  <= 20'd1;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            depth_reg <= depth_next;
            slen_reg  <= slen_next;
            line_reg  <= line_next;
        end
    end

endmodule

// ===== rtl/sexpr_result_queue.sv =====
module sexpr_result_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  sexpr_pkg::lex_out_t lex,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output sexpr_pkg::entry_t   head
);

    localparam int AW = sexpr_pkg::QUEUE_AW;

    sexpr_pkg::entry_t mem [sexpr_pkg::QUEUE_DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic [AW-1:0] wr_ptr_b;
    logic          wr0, wr1;
    logic          rd;
    logic [AW:0]   n_wr;

    assign wr0      = step && lex.v0;
    assign wr1      = step && lex.v1;
    assign rd       = pop && !empty;
    assign wr_ptr_b = wr_ptr_reg + AW'(1);
    assign n_wr     = (AW+1)'(wr0) + (AW+1)'(wr1);

    // pointer and count update
    assign wr_ptr_next = wr_ptr_reg + n_wr[AW-1:0];
    assign rd_ptr_next = rd ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
    assign count_next  = count_reg + n_wr - (AW+1)'(rd);

    // keep room for a two-result byte
    assign full  = (count_reg > (AW+1)'(sexpr_pkg::QUEUE_DEPTH - 2));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr0)
        begin
            mem[wr_ptr_reg] <= '{lex.r0, lex.line};
        end
        if (wr1)
        begin
            mem[wr_ptr_b] <= '{lex.r1, lex.line};
        end
    end

endmodule

// ===== rtl/sexpr_tokenizer_core.sv =====
// the results of a byte taken at a clock edge are visible (empty low) after that edge
// throughput: one byte per cycle when not full; a byte gives 0, 1 or 2 results and one
// result leaves per cycle, so the pop side sets the sustained rate when bytes yield two results
// full is raised when the 4-entry result queue has fewer than two free slots
// reset: asynchronous active low; lexer at token start, line count 1, queue empty
module sexpr_tokenizer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  char_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic [1:0]  token_kind,
    output logic        char_valid,
    output logic        token_last,
    output logic [19:0] line_number
);

    sexpr_pkg::lex_out_t lex;
    sexpr_pkg::entry_t   head;
    logic                step;

    // input transfer
    assign step = push && !full;

    // front: byte classification and lexer state
    sexpr_lexer u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .char_byte (char_byte),
        .lex       (lex)
    );

    // back: result queue feeding the output side
    sexpr_result_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .lex   (lex),
        .pop   (pop),
        .full  (full),
        .empty (empty),
        .head  (head)
    );

    assign out_byte    = head.res.out_byte;
    assign token_kind  = head.res.token_kind;
    assign char_valid  = head.res.char_valid;
    assign token_last  = head.res.token_last;
    assign line_number = head.line;

`ifndef SYNTHESIS
    // a second result never comes without a first
    assert property (@(posedge clk) disable iff (!rst_n) lex.v1 |-> lex.v0)
        else $error("second lexer result without first");

    // a transfer that yields a result shows up at the output next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (step && lex.v0) |=> !empty)
        else $error("accepted result not visible");

    // end markers carry no byte and close the token
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !char_valid) |-> (token_last && out_byte == 8'd0))
        else $error("malformed end marker");

    // line count never drops to zero
    assert property (@(posedge clk) disable iff (!rst_n) !empty |-> (line_number != 20'd0))
        else $error("line number zero");
`endif

endmodule
